/* hw/rtl/bimc_pkg.sv */
// Shared constants and types of the bilinear interpolator with missing corners.
package bimc_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int THRESH_BITS    = 16;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd66;
   localparam int QUEUE_DEPTH    = 4;

   // How the back end forms the result of one request
   typedef enum logic [3:0] {
      MODE_SNAP   = 4'b0001,
      MODE_BILIN  = 4'b0010,
      MODE_EDGE   = 4'b0100,
      MODE_ABSENT = 4'b1000
   } mode_type;

   // Corner slots, in missing-mask bit order
   localparam logic [1:0] CORNER_LL = 2'd0;
   localparam logic [1:0] CORNER_LR = 2'd1;
   localparam logic [1:0] CORNER_HL = 2'd2;
   localparam logic [1:0] CORNER_HR = 2'd3;

   // Edges, in test order
   localparam logic [1:0] EDGE_X1 = 2'd0;
   localparam logic [1:0] EDGE_X2 = 2'd1;
   localparam logic [1:0] EDGE_Y1 = 2'd2;
   localparam logic [1:0] EDGE_Y2 = 2'd3;

   typedef struct packed {
      mode_type   mode;
      logic [1:0] sel;       // snapped corner or chosen edge
      logic [3:0] use_mask;  // corners that take part in the bilinear sum
   } ctrl_type;

endpackage

/* hw/rtl/bilinear_interp_missing_corners.sv */
// Top level of the bilinear interpolator with missing corners.
// Takes one request per clock cycle when the result side keeps up; a result
// passes queue slot, weight, product and sum stages, one divider stage per
// quotient bit and output register. The divider is a fully pipelined restoring
// divider, so the rate is set by nothing but the output handshake: a stalled
// result freezes the back end, and the four-entry queue keeps taking requests
// until it fills. A point nearer a corner than snap_threshold returns that
// corner, or absent if it is missing; otherwise the weights of the present
// corners, bilinear or along the near edge joining two, are renormalized by
// their sum, rounding half away from zero. Write the threshold only while idle.
module bilinear_interp_missing_corners #(
   parameter int VALUE_BITS = bimc_pkg::VALUE_BITS_DEF,
   parameter int FRAC_BITS  = bimc_pkg::FRAC_BITS_DEF,
   localparam int REQ_BITS  = ((2 * (FRAC_BITS + 1) + 4 * VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // low to high: frac_x, frac_y, value_low_left, value_low_right,
   // value_high_right, value_high_left, zero pad
   input  logic [REQ_BITS-1:0]              req_tdata,
   input  logic [3:0]                       req_tuser,   // absent_mask
   input  logic                             req_tvalid,
   output logic                             req_tready,
   output logic [RSP_BITS-1:0]              rsp_tdata,   // result_value, zero pad
   output logic                             rsp_tuser,   // result_absent
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [bimc_pkg::THRESH_BITS-1:0] csr_wdata    // snap_threshold
);
   import bimc_pkg::*;

   localparam int VB = VALUE_BITS;
   localparam int F  = FRAC_BITS;
   localparam int CB = $bits(ctrl_type);
   localparam int QW = CB + 2 * (F + 1) + 4 * VB;
   localparam int VO = 2 * (F + 1);  // first corner value in the request

   logic [F:0]        dx, dy, q_dx, q_dy;
   ctrl_type          ctrl, q_ctrl;
   logic [4*VB-1:0]   values, q_values;
   logic [QW-1:0]     q_din, q_dout;
   logic              q_full, q_empty, push, pop;
   logic [VB-1:0]     result_value;

   // Reorder corners into missing-mask bit order: ll, lr, hl, hr
   assign values = {req_tdata[VO+2*VB +: VB], req_tdata[VO+3*VB +: VB],
                    req_tdata[VO+VB +: VB],   req_tdata[VO +: VB]};

   bimc_front #(.FRAC_BITS(F)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .frac_x      (req_tdata[F:0]),
      .frac_y      (req_tdata[2*F+1:F+1]),
      .absent_mask (req_tuser),
      .dx          (dx),
      .dy          (dy),
      .ctrl        (ctrl)
   );

   // Accept whenever the queue has room
   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;
   assign q_din      = {values, dy, dx, ctrl};

   bimc_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (q_din),
      .full  (q_full),
      .pop   (pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   assign q_ctrl   = ctrl_type'(q_dout[CB-1:0]);
   assign q_dx     = q_dout[CB +: F+1];
   assign q_dy     = q_dout[CB+F+1 +: F+1];
   assign q_values = q_dout[CB+2*(F+1) +: 4*VB];

   bimc_back #(.VALUE_BITS(VB), .FRAC_BITS(F)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!q_empty),
      .in_ctrl    (q_ctrl),
      .in_dx      (q_dx),
      .in_dy      (q_dy),
      .in_values  (q_values),
      .in_pop     (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (result_value),
      .out_absent (rsp_tuser)
   );

   assign rsp_tdata = RSP_BITS'(result_value);

endmodule

/* hw/rtl/bimc_front.sv */
// Front end: threshold register, position clamp and request classification.
module bimc_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bimc_pkg::THRESH_BITS-1:0] csr_wdata,
   input  logic [FRAC_BITS:0]             frac_x,
   input  logic [FRAC_BITS:0]             frac_y,
   input  logic [3:0]                     absent_mask,
   output logic [FRAC_BITS:0]             dx,
   output logic [FRAC_BITS:0]             dy,
   output bimc_pkg::ctrl_type             ctrl
);
   import bimc_pkg::*;

   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam int CW = (FRAC_BITS + 1 > THRESH_BITS) ? FRAC_BITS + 1 : THRESH_BITS;

   logic [THRESH_BITS-1:0] thresh_ff;
   logic [FRAC_BITS:0]     x, y, dx2, dy2;
   logic [CW-1:0]          t;
   logic                   near_x1, near_x2, near_y1, near_y2;
   logic [2:0]             missing;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_we) begin
         thresh_ff <= csr_wdata;
      end
   end

   // Clamp positions above one
   assign x   = (frac_x > ONE) ? ONE : frac_x;
   assign y   = (frac_y > ONE) ? ONE : frac_y;
   assign dx2 = ONE - x;
   assign dy2 = ONE - y;
   assign dx  = x;
   assign dy  = y;

   assign t       = CW'(thresh_ff);
   assign near_x1 = CW'(x) < t;
   assign near_x2 = CW'(dx2) < t;
   assign near_y1 = CW'(y) < t;
   assign near_y2 = CW'(dy2) < t;
   assign missing = 3'(absent_mask[0]) + 3'(absent_mask[1])
                  + 3'(absent_mask[2]) + 3'(absent_mask[3]);

   always_comb begin
      ctrl.mode     = MODE_ABSENT;
      ctrl.sel      = CORNER_LL;
      ctrl.use_mask = ~absent_mask;
      if (near_x1 && near_y1) begin
         ctrl.sel  = CORNER_LL;
         ctrl.mode = absent_mask[0] ? MODE_ABSENT : MODE_SNAP;
      end else if (near_x2 && near_y1) begin
         ctrl.sel  = CORNER_LR;
         ctrl.mode = absent_mask[1] ? MODE_ABSENT : MODE_SNAP;
      end else if (near_x1 && near_y2) begin
         ctrl.sel  = CORNER_HL;
         ctrl.mode = absent_mask[2] ? MODE_ABSENT : MODE_SNAP;
      end else if (near_x2 && near_y2) begin
         ctrl.sel  = CORNER_HR;
         ctrl.mode = absent_mask[3] ? MODE_ABSENT : MODE_SNAP;
      end else if (missing <= 3'd1) begin
         ctrl.mode = MODE_BILIN;
      end else if (missing == 3'd2) begin
         // first near edge decides; its two corners must be the present ones
         if (near_x1) begin
            ctrl.sel  = EDGE_X1;
            ctrl.mode = (absent_mask == 4'b1010) ? MODE_EDGE : MODE_ABSENT;
         end else if (near_x2) begin
            ctrl.sel  = EDGE_X2;
            ctrl.mode = (absent_mask == 4'b0101) ? MODE_EDGE : MODE_ABSENT;
         end else if (near_y1) begin
            ctrl.sel  = EDGE_Y1;
            ctrl.mode = (absent_mask == 4'b1100) ? MODE_EDGE : MODE_ABSENT;
         end else if (near_y2) begin
            ctrl.sel  = EDGE_Y2;
            ctrl.mode = (absent_mask == 4'b0011) ? MODE_EDGE : MODE_ABSENT;
         end
      end
   end

endmodule

/* hw/rtl/bimc_queue.sv */
// Small register queue between the front and back ends.
module bimc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [NW-1:0]    count_ff;

   assign full  = (count_ff == NW'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == LAST) ? '0 : wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == LAST) ? '0 : rd_ff + PW'(1);
         end
         count_ff <= count_ff + NW'(push) - NW'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH)) else $error("queue count out of range");

endmodule

/* hw/rtl/bimc_back.sv */
// Back end: weights, weighted sum and pipelined rounding divider.
module bimc_back #(
   parameter int VALUE_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  bimc_pkg::ctrl_type      in_ctrl,
   input  logic [FRAC_BITS:0]      in_dx,
   input  logic [FRAC_BITS:0]      in_dy,
   input  logic [4*VALUE_BITS-1:0] in_values,
   output logic                    in_pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [VALUE_BITS-1:0]   out_value,
   output logic                    out_absent
);
   import bimc_pkg::*;

   localparam int VB = VALUE_BITS;
   localparam int F  = FRAC_BITS;
   localparam int WW = 2 * F + 2;    // weight
   localparam int DW = WW + 2;       // weight sum
   localparam int PW = VB + WW + 1;  // signed product
   localparam int SW = PW + 2;       // signed sum
   localparam int RW = DW + VB;      // remainder
   localparam logic [F:0] ONE = (F+1)'(1) << F;

   logic en;
   assign en     = !out_valid || out_ready;
   assign in_pop = in_valid && en;

   // Stage 1: corner weights
   logic [F:0]    dx2, dy2;
   logic [WW-1:0] prod_w [4];
   logic [WW-1:0] w [4];
   logic          s1_valid_ff;
   mode_type      s1_mode_ff;
   logic [WW-1:0] s1_w_ff [4];
   logic [VB-1:0] s1_v_ff [4];

   assign dx2       = ONE - in_dx;
   assign dy2       = ONE - in_dy;
   assign prod_w[0] = WW'(dx2) * WW'(dy2);
   assign prod_w[1] = WW'(in_dx) * WW'(dy2);
   assign prod_w[2] = WW'(dx2) * WW'(in_dy);
   assign prod_w[3] = WW'(in_dx) * WW'(in_dy);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         w[i] = '0;
      end
      unique case (in_ctrl.mode)
         MODE_SNAP: begin
            w[in_ctrl.sel] = WW'(1);
         end
         MODE_BILIN: begin
            for (int i = 0; i < 4; i++) begin
               w[i] = in_ctrl.use_mask[i] ? prod_w[i] : '0;
            end
         end
         MODE_EDGE: begin
            case (in_ctrl.sel)
               EDGE_X1: begin
                  w[CORNER_LL] = WW'(dy2);
                  w[CORNER_HL] = WW'(in_dy);
               end
               EDGE_X2: begin
                  w[CORNER_LR] = WW'(dy2);
                  w[CORNER_HR] = WW'(in_dy);
               end
               EDGE_Y1: begin
                  w[CORNER_LL] = WW'(dx2);
                  w[CORNER_LR] = WW'(in_dx);
               end
               default: begin
                  w[CORNER_HL] = WW'(dx2);
                  w[CORNER_HR] = WW'(in_dx);
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mode_ff <= in_ctrl.mode;
         for (int i = 0; i < 4; i++) begin
            s1_w_ff[i] <= w[i];
            s1_v_ff[i] <= in_values[i*VB +: VB];
         end
      end
   end

   // Stage 2: products and weight sum
   logic [DW-1:0]        wsum;
   logic                 s2_valid_ff, s2_absent_ff;
   logic [DW-1:0]        s2_den_ff;
   logic signed [PW-1:0] s2_prod_ff [4];
   logic                 s2_absent_in;
   logic [DW-1:0]        s2_den_in;

   assign wsum = DW'(s1_w_ff[0]) + DW'(s1_w_ff[1]) + DW'(s1_w_ff[2]) + DW'(s1_w_ff[3]);

   always_comb begin
      s2_absent_in = 1'b0;
      s2_den_in    = DW'(1);
      unique case (s1_mode_ff)
         MODE_SNAP: begin
            s2_den_in = DW'(1);
         end
         MODE_BILIN: begin
            // point exactly on a missing corner leaves no weight
            s2_absent_in = (wsum == '0);
            s2_den_in    = (wsum == '0) ? DW'(1) : wsum;
         end
         MODE_EDGE: begin
            s2_den_in = DW'(ONE);
         end
         default: begin
            s2_absent_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            s2_prod_ff[i] <= PW'($signed(s1_v_ff[i]) * $signed({1'b0, s1_w_ff[i]}));
         end
         s2_absent_ff <= s2_absent_in;
         s2_den_ff    <= s2_den_in;
      end
   end

   // Stage 3: signed sum to sign and magnitude
   logic signed [SW-1:0] sum;
   logic [SW-1:0]        mag;

   assign sum = SW'(s2_prod_ff[0]) + SW'(s2_prod_ff[1])
              + SW'(s2_prod_ff[2]) + SW'(s2_prod_ff[3]);
   assign mag = sum[SW-1] ? SW'(-sum) : SW'(sum);

   // Divider stages, one quotient bit each; index 0 holds stage 3
   logic          dv_valid_ff  [VB+1];
   logic          dv_sign_ff   [VB+1];
   logic          dv_absent_ff [VB+1];
   logic [DW-1:0] dv_den_ff    [VB+1];
   logic [RW-1:0] dv_rem_ff    [VB+1];
   logic [VB-1:0] dv_q_ff      [VB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_sign_ff[0]   <= sum[SW-1];
         dv_absent_ff[0] <= s2_absent_ff;
         dv_den_ff[0]    <= s2_den_ff;
         dv_rem_ff[0]    <= RW'(mag);
         dv_q_ff[0]      <= '0;
      end
   end

   for (genvar j = 0; j < VB; j++) begin : g_div
      localparam int K = VB - 1 - j;
      logic [RW-1:0] trial;
      logic          ge;

      assign trial = RW'(dv_den_ff[j]) << K;
      assign ge    = dv_rem_ff[j] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_sign_ff[j+1]   <= dv_sign_ff[j];
            dv_absent_ff[j+1] <= dv_absent_ff[j];
            dv_den_ff[j+1]    <= dv_den_ff[j];
            dv_rem_ff[j+1]    <= ge ? dv_rem_ff[j] - trial : dv_rem_ff[j];
            dv_q_ff[j+1]      <= dv_q_ff[j] | (VB'(ge) << K);
         end
      end
   end

   // Output: round half away from zero, restore sign
   logic [DW:0]   rem2;
   logic          round_up;
   logic [VB-1:0] qr, value;
   logic          out_valid_ff, out_absent_ff;
   logic [VB-1:0] out_value_ff;

   assign rem2     = {dv_rem_ff[VB][DW-1:0], 1'b0};
   assign round_up = rem2 >= {1'b0, dv_den_ff[VB]};
   assign qr       = dv_q_ff[VB] + VB'(round_up);
   assign value    = dv_sign_ff[VB] ? -qr : qr;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid_ff[VB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_absent_ff <= dv_absent_ff[VB];
         out_value_ff  <= dv_absent_ff[VB] ? '0 : value;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_value  = out_value_ff;
   assign out_absent = out_absent_ff;

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_absent |-> out_value == '0) else $error("absent result not zero");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |-> !in_pop) else $error("back end took a request in stall");
   a_result_stable: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_absent))
      else $error("result changed in stall");

endmodule
